// ===== rtl/core/vpcv_pkg.sv =====
// ----------------------------------------------------------------------------
// vpcv_pkg
// Shared widths and types for the vertex projection / cull / viewport block.
// ----------------------------------------------------------------------------
`default_nettype none

package vpcv_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;
    localparam int IDX_W    = 3;
    localparam int VAL_W    = 32;
    // clip coordinates: |c| < 3*2^46 + 2^31, fits 49 bits signed
    localparam int CW       = 49;
    localparam int MW       = CW - 1;
    // quotient magnitude bits: 15 integer + 16 fraction
    localparam int QW       = 31;
    localparam int FRAC     = 16;
    // divider: one setup stage plus one stage per quotient bit
    localparam int DIV_LAT  = QW + 1;
    localparam int XF_LAT   = 2;
    localparam int VP_LAT   = 3;

    localparam logic signed [VAL_W-1:0] ONE_Q   = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] mvp_t;

    // identity matrix, register 7 first
    localparam mvp_t MVP_RESET = {
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
    };

    // divider result for one lane
    typedef struct packed {
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
        logic          n_pos;
        logic          n_neg;
    } div_res_t;

    // per-word data that bypasses the dividers
    typedef struct packed {
        logic             w_zero;
        logic [VAL_W-1:0] cw_sat;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/vpcv_xform.sv =====
// ----------------------------------------------------------------------------
// vpcv_xform
// Matrix times (x, y, z, 1): products registered, then summed and rounded.
// ----------------------------------------------------------------------------
`default_nettype none

module vpcv_xform (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    input  wire vpcv_pkg::mvp_t         mvp,
    input  wire logic signed [31:0]     pos_x,
    input  wire logic signed [31:0]     pos_y,
    input  wire logic signed [31:0]     pos_z,
    output logic                        out_valid,
    output logic signed [vpcv_pkg::CW-1:0] clip_x,
    output logic signed [vpcv_pkg::CW-1:0] clip_y,
    output logic signed [vpcv_pkg::CW-1:0] clip_z,
    output logic signed [vpcv_pkg::CW-1:0] clip_w
);
    import vpcv_pkg::*;

    localparam int SUM_W = 66;

    logic signed [63:0]       prod_reg [4][3];
    logic signed [31:0]       m3_reg   [4];
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [CW-1:0]     clip_reg [4];
    logic signed [31:0]       vin      [3];
    logic signed [SUM_W-1:0]  sum      [4];

    assign vin[0] = pos_x;
    assign vin[1] = pos_y;
    assign vin[2] = pos_z;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[r][k] <= $signed(mvp[r*2 + k/2][(k%2)*32 +: 32]) * vin[k];
            end
            m3_reg[r] <= $signed(mvp[r*2 + 1][63:32]);
        end
    end

    // exact sum, round half up, drop 16 fraction bits
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                   + SUM_W'(prod_reg[r][2])
                   + (SUM_W'(m3_reg[r]) <<< FRAC)
                   + SUM_W'(32'sh0000_8000);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            clip_reg[r] <= sum[r][FRAC +: CW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign clip_x    = clip_reg[0];
    assign clip_y    = clip_reg[1];
    assign clip_z    = clip_reg[2];
    assign clip_w    = clip_reg[3];

endmodule

`default_nettype wire

// ===== rtl/core/vpcv_div.sv =====
// ----------------------------------------------------------------------------
// vpcv_div
// Pipelined restoring divider, one quotient bit per stage, Q15.16 result
// magnitude with an overflow flag for integer parts of 2^15 and above.
// ----------------------------------------------------------------------------
`default_nettype none

module vpcv_div (
    input  wire                            clk,
    input  wire logic signed [vpcv_pkg::CW-1:0] num,
    input  wire logic signed [vpcv_pkg::CW-1:0] den,
    output vpcv_pkg::div_res_t             res
);
    import vpcv_pkg::*;

    localparam int LOW_W = QW - FRAC;

    typedef struct packed {
        logic ovf;
        logic neg;
        logic n_pos;
        logic n_neg;
    } flag_t;

    logic [MW-1:0]    rem_reg  [QW+1];
    logic [MW-1:0]    den_reg  [QW+1];
    logic [LOW_W-1:0] nlow_reg [QW+1];
    logic [QW-1:0]    q_reg    [QW+1];
    flag_t            flag_reg [QW+1];

    logic signed [CW-1:0] num_abs;
    logic signed [CW-1:0] den_abs;
    logic [MW-1:0]        un;
    logic [MW-1:0]        ud;
    logic [MW-1:0]        rem0;

    always_comb
    begin
        num_abs = num[CW-1] ? -num : num;
        den_abs = den[CW-1] ? -den : den;
        un      = num_abs[MW-1:0];
        ud      = den_abs[MW-1:0];
        rem0    = MW'(un[MW-1:LOW_W]);
    end

    // setup stage
    always_ff @(posedge clk)
    begin
        rem_reg[0]        <= rem0;
        den_reg[0]        <= ud;
        nlow_reg[0]       <= un[LOW_W-1:0];
        q_reg[0]          <= '0;
        flag_reg[0].ovf   <= (rem0 >= ud);
        flag_reg[0].neg   <= num[CW-1] ^ den[CW-1];
        flag_reg[0].n_pos <= !num[CW-1] && (num != '0);
        flag_reg[0].n_neg <= num[CW-1];
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_stage
        localparam int BIT = QW - s;
        logic          nbit;
        logic [MW:0]   trial;

        if (BIT >= FRAC)
        begin : g_num
            assign nbit = nlow_reg[s-1][BIT-FRAC];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_reg[s-1], nbit} - {1'b0, den_reg[s-1]};

        always_ff @(posedge clk)
        begin
            den_reg[s]  <= den_reg[s-1];
            nlow_reg[s] <= nlow_reg[s-1];
            flag_reg[s] <= flag_reg[s-1];
            if (!trial[MW])
            begin
                rem_reg[s]    <= trial[MW-1:0];
                q_reg[s]      <= q_reg[s-1] | (QW'(1) << BIT);
            end
            else
            begin
                rem_reg[s]    <= {rem_reg[s-1][MW-2:0], nbit};
                q_reg[s]      <= q_reg[s-1];
            end
        end
    end

    assign res.q     = q_reg[QW];
    assign res.ovf   = flag_reg[QW].ovf;
    assign res.neg   = flag_reg[QW].neg;
    assign res.n_pos = flag_reg[QW].n_pos;
    assign res.n_neg = flag_reg[QW].n_neg;

endmodule

`default_nettype wire

// ===== rtl/core/vpcv_view.sv =====
// ----------------------------------------------------------------------------
// vpcv_view
// NDC saturation, clip test and viewport mapping over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module vpcv_view #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    input  wire vpcv_pkg::side_t     side,
    input  wire vpcv_pkg::div_res_t  dx,
    input  wire vpcv_pkg::div_res_t  dy,
    input  wire vpcv_pkg::div_res_t  dz,
    output logic                     out_valid,
    output logic signed [31:0]       screen_x,
    output logic signed [31:0]       screen_y,
    output logic signed [31:0]       depth,
    output logic signed [31:0]       clip_w,
    output logic                     culled
);
    import vpcv_pkg::*;

    localparam int DW = $clog2(SCREEN_WIDTH + 1) + 1;
    localparam int DH = $clog2(SCREEN_HEIGHT + 1) + 1;
    localparam int TW = VAL_W + 1;
    localparam int PW = TW + ((DW > DH) ? DW : DH);
    localparam logic signed [DW-1:0] SW_S = DW'(SCREEN_WIDTH);
    localparam logic signed [DH-1:0] SH_S = DH'(SCREEN_HEIGHT);

    function automatic logic signed [VAL_W-1:0] ndc_val(div_res_t d, logic w_zero);
        logic signed [VAL_W-1:0] v;
        if (w_zero)
        begin
            v = d.n_pos ? VAL_MAX : (d.n_neg ? VAL_MIN : '0);
        end
        else if (d.ovf)
        begin
            v = d.neg ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            v = d.neg ? -$signed({1'b0, d.q}) : $signed({1'b0, d.q});
        end
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_half(logic signed [PW-1:0] t);
        logic signed [PW-1:0] h;
        h = t >>> 1;
        if (h > PW'(VAL_MAX))
        begin
            return VAL_MAX;
        end
        else if (h < PW'(VAL_MIN))
        begin
            return VAL_MIN;
        end
        return h[VAL_W-1:0];
    endfunction

    logic signed [VAL_W-1:0] nx;
    logic signed [VAL_W-1:0] ny;
    logic signed [VAL_W-1:0] nz;
    logic                    cull_c;

    logic signed [VAL_W-1:0] nx_reg;
    logic signed [VAL_W-1:0] ny_reg;
    logic signed [VAL_W-1:0] nz1_reg;
    logic [VAL_W-1:0]        cw1_reg;
    logic                    cull1_reg;
    logic signed [PW-1:0]    tx_reg;
    logic signed [PW-1:0]    ty_reg;
    logic signed [VAL_W-1:0] nz2_reg;
    logic [VAL_W-1:0]        cw2_reg;
    logic                    cull2_reg;
    logic signed [VAL_W-1:0] sx_reg;
    logic signed [VAL_W-1:0] sy_reg;
    logic signed [VAL_W-1:0] nz3_reg;
    logic [VAL_W-1:0]        cw3_reg;
    logic                    cull3_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic signed [TW-1:0]    ax;
    logic signed [TW-1:0]    ay;

    always_comb
    begin
        nx = ndc_val(dx, side.w_zero);
        ny = ndc_val(dy, side.w_zero);
        nz = ndc_val(dz, side.w_zero);
        cull_c = side.w_zero
               || (nx < -ONE_Q) || (nx > ONE_Q)
               || (ny < -ONE_Q) || (ny > ONE_Q)
               || (nz < 0) || (nz > ONE_Q);
        ax = TW'(nx_reg) + TW'(ONE_Q);
        ay = TW'(ONE_Q) - TW'(ny_reg);
    end

    always_ff @(posedge clk)
    begin
        nx_reg    <= nx;
        ny_reg    <= ny;
        nz1_reg   <= nz;
        cw1_reg   <= side.cw_sat;
        cull1_reg <= cull_c;

        tx_reg    <= PW'(ax * SW_S);
        ty_reg    <= PW'(ay * SH_S);
        nz2_reg   <= nz1_reg;
        cw2_reg   <= cw1_reg;
        cull2_reg <= cull1_reg;

        sx_reg    <= sat_half(tx_reg);
        sy_reg    <= sat_half(ty_reg);
        nz3_reg   <= nz2_reg;
        cw3_reg   <= cw2_reg;
        cull3_reg <= cull2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign depth     = nz3_reg;
    assign clip_w    = cw3_reg;
    assign culled    = cull3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_project_cull_viewport_top.sv =====
// ----------------------------------------------------------------------------
// vertex_project_cull_viewport_top
// Projects a Q16.16 vertex through a 4x4 matrix, divides by w, culls against
// the clip volume and maps to screen pixels.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------
//  vertex   | pos_x, pos_y, pos_z                     | start, busy
//  result   | screen_x, screen_y, depth, clip_w, culled | done (one cycle)
//  config   | cfg_addr, cfg_data                      | cfg_we
//
// One word per clock. Words pass through the matrix products and sum, the
// pipelined dividers (one quotient bit per stage), then NDC/viewport.
// busy is always low. Reset clears the valid bits and loads the identity
// matrix. The receiver cannot stall, so nothing ever backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_project_cull_viewport_top #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire logic signed [31:0]             pos_x,
    input  wire logic signed [31:0]             pos_y,
    input  wire logic signed [31:0]             pos_z,
    output logic                                done,
    output logic signed [31:0]                  screen_x,
    output logic signed [31:0]                  screen_y,
    output logic signed [31:0]                  depth,
    output logic signed [31:0]                  clip_w,
    output logic                                culled,
    input  wire                                 cfg_we,
    input  wire [vpcv_pkg::IDX_W-1:0]           cfg_addr,
    input  wire [vpcv_pkg::REG_W-1:0]           cfg_data
);
    import vpcv_pkg::*;

    localparam int TOTAL_LAT = XF_LAT + DIV_LAT + VP_LAT;

    mvp_t                 mvp_reg;
    logic                 xf_valid;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic signed [CW-1:0] cw;
    side_t                side_next;
    side_t                side_reg  [DIV_LAT];
    logic                 vld_reg   [DIV_LAT];
    div_res_t             dx;
    div_res_t             dy;
    div_res_t             dz;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvp_reg <= MVP_RESET;
        end
        else if (cfg_we)
        begin
            mvp_reg[cfg_addr] <= cfg_data;
        end
    end

    vpcv_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .mvp       (mvp_reg),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .out_valid (xf_valid),
        .clip_x    (cx),
        .clip_y    (cy),
        .clip_z    (cz),
        .clip_w    (cw)
    );

    vpcv_div u_div_x (.clk(clk), .num(cx), .den(cw), .res(dx));
    vpcv_div u_div_y (.clk(clk), .num(cy), .den(cw), .res(dy));
    vpcv_div u_div_z (.clk(clk), .num(cz), .den(cw), .res(dz));

    always_comb
    begin
        side_next.w_zero = (cw == '0);
        if (cw > CW'(VAL_MAX))
        begin
            side_next.cw_sat = VAL_MAX;
        end
        else if (cw < CW'(VAL_MIN))
        begin
            side_next.cw_sat = VAL_MIN;
        end
        else
        begin
            side_next.cw_sat = cw[VAL_W-1:0];
        end
    end

    // w side data and valid ride alongside the dividers
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= xf_valid;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    vpcv_view #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_view (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[DIV_LAT-1]),
        .side      (side_reg[DIV_LAT-1]),
        .dx        (dx),
        .dy        (dy),
        .dz        (dz),
        .out_valid (done),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .depth     (depth),
        .clip_w    (clip_w),
        .culled    (culled)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result word without matching vertex");

    a_wzero_culled: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clip_w == '0) |-> culled)
        else $error("zero w not culled");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !culled) |-> (depth >= 0 && depth <= ONE_Q))
        else $error("visible vertex with depth outside [0,1]");

endmodule

`default_nettype wire

// ===== test/vertex_project_cull_viewport_top_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_project_cull_viewport_top_tb
// Drives vertices through the projection/cull/viewport block under several
// matrices and idle patterns; checks every result word against a typed-in
// value or a fixed-point predictor of transform, divide, clip test, viewport.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_project_cull_viewport_top_tb;

    import vpcv_pkg::*;

    localparam int SCR_W   = 1024;
    localparam int SCR_H   = 768;
    localparam int LAT     = 37;
    localparam int N_RAND  = 1300;
    localparam int N_DIR   = 14;
    localparam int EXP_D   = 256;

    localparam logic [IDX_W-1:0] REG_ROW0_LO = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW3_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_ROW3_HI = 3'd7;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] dz;
        logic signed [31:0] cw;
        logic               cull;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               has_exp;
        pixel_t             exp_px;
    } vtx_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0] cfg_data = '0;
    wire busy, done, culled;
    wire signed [31:0] screen_x, screen_y, depth, clip_w;

    logic [REG_W-1:0] mvp [NUM_REGS];
    // expected words in flight, written at accept, read at done
    pixel_t exp_fifo [EXP_D];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    int idle_pct = 0;

    vertex_project_cull_viewport_top #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .screen_x(screen_x), .screen_y(screen_y), .depth(depth),
        .clip_w(clip_w), .culled(culled),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20000000;
        $display("vertex_project_cull_viewport_top verification failed");
        $finish;
    end

    function automatic longint sat_val(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint entry_of(int r, int c);
        logic [63:0] reg_v;
        reg_v = mvp[r * 2 + c / 2];
        return (c % 2) ? longint'($signed(reg_v[63:32])) : longint'($signed(reg_v[31:0]));
    endfunction

    // exact 128-bit sum of Q32.32 products, rounded half-up to Q16.16
    function automatic longint clip_coord(int r, longint vx, longint vy, longint vz);
        logic signed [127:0] acc;
        longint vin [4];
        vin[0] = vx; vin[1] = vy; vin[2] = vz; vin[3] = 65536;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += 128'(entry_of(r, k)) * 128'(vin[k]);
        acc = (acc + 128'sd32768) >>> 16;
        return longint'(acc);
    endfunction

    function automatic longint ndc_div(longint n, longint d);
        logic [63:0] un, ud, ip, rem, frac;
        logic [63:0] q;
        logic neg;
        if (d == 0)
            return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        ip = un / ud;
        if (ip >= 32768)
            q = 64'h8000_0000;
        else
        begin
            rem = un % ud;
            frac = 0;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= ud)
                begin
                    rem -= ud;
                    frac[0] = 1'b1;
                end
            end
            q = (ip << 16) | frac;
        end
        return sat_val(neg ? -longint'(q) : longint'(q));
    endfunction

    function automatic pixel_t project_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] z);
        pixel_t px;
        longint cx, cy, cz, cw, nx, ny, nz;
        cx = clip_coord(0, x, y, z);
        cy = clip_coord(1, x, y, z);
        cz = clip_coord(2, x, y, z);
        cw = clip_coord(3, x, y, z);
        nx = ndc_div(cx, cw);
        ny = ndc_div(cy, cw);
        nz = ndc_div(cz, cw);
        px.cull = (cw == 0) || nx < -65536 || nx > 65536 || ny < -65536 || ny > 65536
                  || nz < 0 || nz > 65536;
        px.sx = 32'(sat_val(((nx + 65536) * SCR_W) >>> 1));
        px.sy = 32'(sat_val(((65536 - ny) * SCR_H) >>> 1));
        px.dz = 32'(nz);
        px.cw = 32'(sat_val(cw));
        return px;
    endfunction

    always @(posedge clk)
    begin
        if (done)
        begin
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result word sx=%h", $time, screen_x);
                errors++;
            end
            else
            begin
                pixel_t e;
                e = exp_fifo[exp_rd % EXP_D];
                exp_rd++;
                if (screen_x !== e.sx)
                begin
                    $display("%0t: screen_x exp %h got %h", $time, e.sx, screen_x);
                    errors++;
                end
                if (screen_y !== e.sy)
                begin
                    $display("%0t: screen_y exp %h got %h", $time, e.sy, screen_y);
                    errors++;
                end
                if (depth !== e.dz)
                begin
                    $display("%0t: depth exp %h got %h", $time, e.dz, depth);
                    errors++;
                end
                if (clip_w !== e.cw)
                begin
                    $display("%0t: clip_w exp %h got %h", $time, e.cw, clip_w);
                    errors++;
                end
                if (culled !== e.cull)
                begin
                    $display("%0t: culled exp %b got %b", $time, e.cull, culled);
                    errors++;
                end
            end
        end
    end

    // one write: cfg_we is raised, then dropped again before the task returns
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        mvp[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // a typed-in expectation, when given, stands in for the predictor
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic has_exp, pixel_t exp_px);
        pixel_t px;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        px = project_vertex(x, y, z);
        if (has_exp)
            px = exp_px;
        do
            @(posedge clk);
        while (busy);
        exp_fifo[exp_wr % EXP_D] = px;
        exp_wr++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(262144)) - 131072);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return $urandom_range(1) ? 32'h0001_0000 : 32'h0;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    vtx_row_t dir_rows [N_DIR];

    initial
    begin
        mvp[0] = 64'h0000_0000_0001_0000;
        mvp[1] = 64'h0;
        mvp[2] = 64'h0001_0000_0000_0000;
        mvp[3] = 64'h0;
        mvp[4] = 64'h0;
        mvp[5] = 64'h0000_0000_0001_0000;
        mvp[6] = 64'h0;
        mvp[7] = 64'h0001_0000_0000_0000;

        // identity matrix after reset: ndc = pos, w = 1
        dir_rows[0] = '{32'sh0, 32'sh0, 32'sh0, 1'b1,
                        '{32'sd33554432, 32'sd25165824, 32'sh0, 32'sh10000, 1'b0}};
        dir_rows[1] = '{32'sh10000, -32'sh10000, 32'sh10000, 1'b1,
                        '{32'sd67108864, 32'sd50331648, 32'sh10000, 32'sh10000, 1'b0}};
        dir_rows[2] = '{-32'sh10000, 32'sh10000, 32'sh0, 1'b1,
                        '{32'sh0, 32'sh0, 32'sh0, 32'sh10000, 1'b0}};
        dir_rows[3] = '{32'sh10001, 32'sh0, 32'sh0, 1'b1,
                        '{32'sd67109376, 32'sd25165824, 32'sh0, 32'sh10000, 1'b1}};
        dir_rows[4] = '{32'sh0, 32'sh0, -32'sh1, 1'b1,
                        '{32'sd33554432, 32'sd25165824, -32'sh1, 32'sh10000, 1'b1}};
        dir_rows[5] = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '0};
        dir_rows[6] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, '0};
        dir_rows[7] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 1'b0, '0};
        dir_rows[8] = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh10001, 1'b0, '0};
        dir_rows[9] = '{32'sh8000, -32'sh8000, 32'sh8000, 1'b0, '0};
        dir_rows[10] = '{32'shFFFF, 32'shFFFF, 32'shFFFF, 1'b0, '0};
        dir_rows[11] = '{-32'sh1, 32'sh1, 32'sh5555, 1'b0, '0};
        dir_rows[12] = '{32'shAAAAAAAA, 32'sh55555555, 32'sh12345678, 1'b0, '0};
        dir_rows[13] = '{32'sh55555555, 32'shAAAAAAAA, 32'shEDCBA987, 1'b0, '0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                        dir_rows[i].has_exp, dir_rows[i].exp_px);
        drain();

        // zero w: row 3 all zero, numerators of each sign and zero
        write_reg(REG_ROW3_LO, 64'h0);
        write_reg(REG_ROW3_HI, 64'h0);
        send_vertex(32'sh10000, -32'sh10000, 32'sh0, 1'b0, '0);
        send_vertex(-32'sh20000, 32'sh20000, 32'sh30000, 1'b0, '0);
        send_vertex(32'sh0, 32'sh0, 32'sh0, 1'b0, '0);
        drain();
        // w = z: w from position, quotient overflow for small z
        write_reg(REG_ROW3_HI, 64'h0000_0000_0001_0000);
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh1, 1'b0, '0);
        send_vertex(32'sh10000, 32'sh10000, -32'sh1, 1'b0, '0);
        drain();

        // random phases: each picks a new matrix and idle pattern
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 73;
                default: idle_pct = 33;
            endcase
            for (int r = 0; r < NUM_REGS; r++)
            begin
                logic [REG_W-1:0] val;
                if (ph == 7)
                    val = (r % 2) ? 64'h8000_0000_8000_0000 : 64'h7FFF_FFFF_7FFF_FFFF;
                else if (ph % 2)
                    val = {rand_entry(), rand_entry()};
                else
                    val = {$urandom, $urandom};
                // keep w mostly sane so many vertices land inside the volume
                if (ph == 2 && r == 7)
                    val = {32'h0001_0000, 32'($signed($urandom_range(2048)) - 1024)};
                if (ph == 2 && r == 6)
                    val = {32'($signed($urandom_range(2048)) - 1024),
                           32'($signed($urandom_range(2048)) - 1024)};
                write_reg(REG_ROW0_LO + IDX_W'(r), val);
            end
            for (int n = 0; n < N_RAND / 8; n++)
                send_vertex(rand_q(), rand_q(), rand_q(), 1'b0, '0);
            drain();
        end

        if (errors == 0)
            $display("vertex_project_cull_viewport_top verification clean");
        else
            $display("vertex_project_cull_viewport_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
